// ===== sv/bpcc_pkg.sv =====
package bpcc_pkg;

    // Table size and lane organization
    localparam int MAX_OBSTACLES = 16;
    localparam int NUM_LANES     = 2;   // power of two
    localparam int LANE_W        = $clog2(NUM_LANES);
    localparam int BANK_DEPTH    = (MAX_OBSTACLES + NUM_LANES - 1) / NUM_LANES;
    localparam int BANK_AW       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int CNT_W         = $clog2(MAX_OBSTACLES + 1);
    localparam int IDX_W         = $clog2(MAX_OBSTACLES + NUM_LANES) + 1;

    // Arithmetic widths
    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int PAIR_W  = PROD_W + 1;
    localparam int COEF_W  = 56;
    localparam int THR_W   = 40;
    localparam int BOUND_W = THR_W + 5;
    localparam int ID_W    = 16;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(23593);

    // Lane latency from read data to fail flag
    localparam int LANE_LAT = 4;
    localparam int FL_W     = $clog2(LANE_LAT + 1);

    // Operation codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_TEST  = 2'd2;

    // Degree-6 Bernstein scaling
    localparam int NCOEF = 7;
    localparam int BINOM6 [NCOEF] = '{1, 6, 15, 20, 15, 6, 1};

    // Unordered control-point index pairs (a <= b)
    localparam int NPAIR = 10;
    localparam int PAIR_A [NPAIR] = '{0, 0, 0, 0, 1, 1, 1, 2, 2, 3};
    localparam int PAIR_B [NPAIR] = '{0, 1, 2, 3, 1, 2, 3, 2, 3, 3};
    localparam int P00 = 0;
    localparam int P01 = 1;
    localparam int P02 = 2;
    localparam int P03 = 3;
    localparam int P11 = 4;
    localparam int P12 = 5;
    localparam int P13 = 6;
    localparam int P22 = 7;
    localparam int P23 = 8;
    localparam int P33 = 9;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t [3:0] x;
        coord_t [3:0] y;
    } curve_t;

    typedef logic [NCOEF-1:0][BOUND_W-1:0] bound_vec_t;

    typedef struct packed {
        logic valid;
        logic fail;
    } lane_res_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_FLUSH  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

endpackage

// ===== sv/bpcc_ram.sv =====
module bpcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/bpcc_lane.sv =====
module bpcc_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  bpcc_pkg::curve_t    cand,
    input  bpcc_pkg::curve_t    obs,
    input  bpcc_pkg::bound_vec_t bound,
    output bpcc_pkg::lane_res_t res
);
    import bpcc_pkg::*;

    logic signed [DIFF_W-1:0] dx_reg [4];
    logic signed [DIFF_W-1:0] dy_reg [4];
    logic signed [DIFF_W-1:0] dx_next [4];
    logic signed [DIFF_W-1:0] dy_next [4];
    logic signed [PROD_W-1:0] px_reg [NPAIR];
    logic signed [PROD_W-1:0] py_reg [NPAIR];
    logic signed [PAIR_W-1:0] pp_reg [NPAIR];
    logic signed [COEF_W-1:0] pe [NPAIR];
    logic signed [COEF_W-1:0] coef [NCOEF];
    logic [NCOEF-1:0]         below;
    logic [2:0]               vld_reg;
    logic                     res_valid_reg;
    logic                     fail_reg;
    logic                     fail_next;

    // Control-point differences
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            dx_next[k] = DIFF_W'($signed(cand.x[k])) - DIFF_W'($signed(obs.x[k]));
            dy_next[k] = DIFF_W'($signed(cand.y[k])) - DIFF_W'($signed(obs.y[k]));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            dx_reg[k] <= dx_next[k];
            dy_reg[k] <= dy_next[k];
        end
    end

    // Pair products, then pair sums dx_a*dx_b + dy_a*dy_b
    for (genvar p = 0; p < NPAIR; p++)
    begin : g_pair
        always_ff @(posedge clk)
        begin
            px_reg[p] <= dx_reg[PAIR_A[p]] * dx_reg[PAIR_B[p]];
            py_reg[p] <= dy_reg[PAIR_A[p]] * dy_reg[PAIR_B[p]];
            pp_reg[p] <= PAIR_W'(px_reg[p]) + PAIR_W'(py_reg[p]);
        end
        assign pe[p] = COEF_W'(pp_reg[p]);
    end

    // Scaled Bernstein coefficients of the squared distance
    always_comb
    begin
        coef[0] = pe[P00];
        coef[1] = pe[P01] * COEF_W'(6);
        coef[2] = pe[P02] * COEF_W'(6) + pe[P11] * COEF_W'(9);
        coef[3] = pe[P03] * COEF_W'(2) + pe[P12] * COEF_W'(18);
        coef[4] = pe[P13] * COEF_W'(6) + pe[P22] * COEF_W'(9);
        coef[5] = pe[P23] * COEF_W'(6);
        coef[6] = pe[P33];
        for (int j = 0; j < NCOEF; j++)
        begin
            below[j] = coef[j] < $signed({{(COEF_W - BOUND_W){1'b0}}, bound[j]});
        end
        fail_next = |below;
    end

    always_ff @(posedge clk)
    begin
        fail_reg <= fail_next;
    end

    // Advance the valid flags alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= {vld_reg[1:0], in_valid};
            res_valid_reg <= vld_reg[2];
        end
    end

    assign res = '{valid: res_valid_reg, fail: fail_reg};

endmodule

// ===== sv/bezier_pair_clearance_check_top.sv =====
// Clearance checker for planar cubic Bezier trajectories. The block holds up to
// MAX_OBSTACLES obstacle curves (16 here). A clear transaction empties the table
// and an add transaction stores one obstacle (dropped when the table is full);
// neither gives a result. A test transaction compares the candidate curve
// against every stored obstacle through the scaled Bernstein coefficients of
// the squared distance and returns tested_id with is_safe. A test holds
// in_ready low from its accept until its result is loaded, and it cannot
// load while the previous result still waits in the output register. In a test,
// two lanes each read one obstacle per cycle from their own RAM bank, and
// each lane is a five-stage pipeline (read, difference, product, pair sum,
// compare) followed by the merge. Results sit in an output register,
// so the next transaction is accepted while a result waits to be taken.
// min_separation_squared is written through config_we/config_data; the user
// must do so only while idle, as the block itself does not enforce it.
module bezier_pair_clearance_check_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             config_we,
    input  logic [bpcc_pkg::THR_W-1:0]       config_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       operation,
    input  logic [bpcc_pkg::ID_W-1:0]        candidate_id,
    input  logic signed [bpcc_pkg::COORD_W-1:0] ctrl_x0,
    input  logic signed [bpcc_pkg::COORD_W-1:0] ctrl_x1,
    input  logic signed [bpcc_pkg::COORD_W-1:0] ctrl_x2,
    input  logic signed [bpcc_pkg::COORD_W-1:0] ctrl_x3,
    input  logic signed [bpcc_pkg::COORD_W-1:0] ctrl_y0,
    input  logic signed [bpcc_pkg::COORD_W-1:0] ctrl_y1,
    input  logic signed [bpcc_pkg::COORD_W-1:0] ctrl_y2,
    input  logic signed [bpcc_pkg::COORD_W-1:0] ctrl_y3,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [bpcc_pkg::ID_W-1:0]        tested_id,
    output logic                             is_safe
);
    import bpcc_pkg::*;

    state_t              state_reg, state_next;
    logic [THR_W-1:0]    thr_reg;
    bound_vec_t          bound_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    count_ext;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [FL_W-1:0]     flush_reg, flush_next;
    curve_t              cand_reg;
    logic [ID_W-1:0]     id_reg;
    logic                unsafe_reg, unsafe_next;
    logic                out_valid_reg, out_valid_next;
    logic [ID_W-1:0]     tested_id_reg;
    logic                is_safe_reg;
    logic [NUM_LANES-1:0] rvld_reg, rvld_next;
    curve_t              in_curve;
    curve_t              bank_rdata [NUM_LANES];
    lane_res_t           lane_res [NUM_LANES];
    logic [NUM_LANES-1:0] lane_fail;
    logic                accept;
    logic                add_ok;
    logic                load_out;

    assign in_curve.x = {ctrl_x3, ctrl_x2, ctrl_x1, ctrl_x0};
    assign in_curve.y = {ctrl_y3, ctrl_y2, ctrl_y1, ctrl_y0};

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign add_ok    = accept && (operation == OP_ADD) &&
                       (count_reg < CNT_W'(MAX_OBSTACLES));
    assign count_ext = IDX_W'(count_reg);
    assign load_out  = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    // Hold the threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (config_we)
        begin
            thr_reg <= config_data;
        end
    end

    // Per-coefficient bounds binom(6,j) * threshold
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NCOEF; j++)
        begin
            bound_reg[j] <= BOUND_W'(thr_reg) * BOUND_W'(BINOM6[j]);
        end
    end

    // Obstacle banks: obstacle i lives in bank i mod NUM_LANES
    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        logic bank_we;
        assign bank_we = add_ok && (count_ext[LANE_W-1:0] == LANE_W'(l));

        bpcc_ram #(
            .WIDTH ($bits(curve_t)),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we),
            .waddr (count_ext[LANE_W +: BANK_AW]),
            .wdata (in_curve),
            .re    (rvld_next[l]),
            .raddr (idx_reg[LANE_W +: BANK_AW]),
            .rdata (bank_rdata[l])
        );

        bpcc_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (rvld_reg[l]),
            .cand     (cand_reg),
            .obs      (bank_rdata[l]),
            .bound    (bound_reg),
            .res      (lane_res[l])
        );

        assign lane_fail[l] = lane_res[l].valid && lane_res[l].fail;

        // Issue a read for this lane while its obstacle is in the table
        assign rvld_next[l] = (state_reg == ST_RUN) &&
                              ((idx_reg + IDX_W'(l)) < count_ext);
    end

    // Sequencer and merge of the lane findings
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        flush_next     = flush_reg;
        unsafe_next    = unsafe_reg | (|lane_fail);
        out_valid_next = out_valid_reg && !out_ready;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_ADD:
                        begin
                            if (add_ok)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_TEST:
                        begin
                            idx_next    = '0;
                            unsafe_next = 1'b0;
                            state_next  = ST_RUN;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                idx_next = idx_reg + IDX_W'(NUM_LANES);
                if ((idx_reg + IDX_W'(NUM_LANES)) >= count_ext)
                begin
                    flush_next = FL_W'(LANE_LAT);
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (flush_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    flush_next = flush_reg - FL_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            flush_reg     <= '0;
            unsafe_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            rvld_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            flush_reg     <= flush_next;
            unsafe_reg    <= unsafe_next;
            out_valid_reg <= out_valid_next;
            rvld_reg      <= rvld_next;
        end
    end

    // Capture the candidate and load the result register
    always_ff @(posedge clk)
    begin
        if (accept && (operation == OP_TEST))
        begin
            cand_reg <= in_curve;
            id_reg   <= candidate_id;
        end
        if (load_out)
        begin
            tested_id_reg <= id_reg;
            is_safe_reg   <= !unsafe_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign tested_id = tested_id_reg;
    assign is_safe   = is_safe_reg;

endmodule
